>>> rtl/npc_pkg.sv
package npc_pkg;

	localparam logic [2:0] OP_LOAD_OFFSET = 3'd0;
	localparam logic [2:0] OP_LOAD_EDGE   = 3'd1;
	localparam logic [2:0] OP_BUILD_FIRST = 3'd2;
	localparam logic [2:0] OP_BUILD_NEXT  = 3'd3;
	localparam logic [2:0] OP_READ        = 3'd4;

	localparam int CNT_W = 48;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [2:0] op;
		logic [8:0] slot;
		logic [9:0] offset_value;
		logic [5:0] pred_node;
		logic [15:0] edge_weight;
		logic [5:0] start_node;
	} item_t;

	// controller to datapath
	typedef struct packed {
		logic clear_sat;
		logic set_sat;
	} npc_cmd_t;

endpackage

>>> rtl/npc_ram.sv
module npc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/npc_datapath.sv
// memories plus sum / multiply / saturate arithmetic
module npc_datapath
	import npc_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 512,
	localparam int NW = $clog2(MAX_NODES + 1),
	localparam int EW = $clog2(MAX_EDGES),
	localparam int RW = $clog2(MAX_NODES),
	localparam int OW = $clog2(MAX_EDGES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	// offset table
	input  logic              off_we,
	input  logic [NW-1:0]     off_waddr,
	input  logic [OW-1:0]     off_wdata,
	input  logic [NW-1:0]     off_raddr,
	output logic [OW-1:0]     off_rdata,
	// edge tables
	input  logic              edge_we,
	input  logic [EW-1:0]     edge_waddr,
	input  logic [5:0]        edge_wpred,
	input  logic [15:0]       edge_wweight,
	input  logic [EW-1:0]     edge_raddr,
	output logic [5:0]        edge_rpred,
	output logic [15:0]       edge_rweight,
	// count banks, bank select chosen by controller
	input  logic              cnt_we_a,
	input  logic              cnt_we_b,
	input  logic [RW+EW-1:0]  cnt_waddr,
	input  logic [CNT_W-1:0]  cnt_wdata,
	input  logic [RW+EW-1:0]  cnt_raddr,
	input  logic              cnt_rsel,
	output logic [CNT_W-1:0]  cnt_rdata,
	// accumulator and product
	input  logic              acc_clear,
	input  logic              acc_add,
	output logic [CNT_W-1:0]  acc,
	input  logic              mul_go,
	input  logic [15:0]       mul_weight,
	output logic [CNT_W-1:0]  prod,
	input  npc_cmd_t          cmd,
	output logic              sat
);

	localparam int CD = MAX_NODES * MAX_EDGES;

	logic [CNT_W-1:0] ra, rb, acc_q, prod_q, sum;
	logic [CNT_W+15:0] mul_full;
	logic acc_ovf, mul_ovf, sat_q, sel_q;

	npc_ram #(.WIDTH(OW), .DEPTH(MAX_NODES + 1)) u_off (
		.clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
		.raddr(off_raddr), .rdata(off_rdata));
	npc_ram #(.WIDTH(6), .DEPTH(MAX_EDGES)) u_pred (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wpred),
		.raddr(edge_raddr), .rdata(edge_rpred));
	npc_ram #(.WIDTH(16), .DEPTH(MAX_EDGES)) u_wt (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wweight),
		.raddr(edge_raddr), .rdata(edge_rweight));
	npc_ram #(.WIDTH(CNT_W), .DEPTH(CD)) u_bank_a (
		.clk(clk), .we(cnt_we_a), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(ra));
	npc_ram #(.WIDTH(CNT_W), .DEPTH(CD)) u_bank_b (
		.clk(clk), .we(cnt_we_b), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(rb));

	always_ff @(posedge clk)
		sel_q <= cnt_rsel;
	assign cnt_rdata = sel_q ? rb : ra;

	assign {acc_ovf, sum} = {1'b0, acc_q} + {1'b0, cnt_rdata};
	assign mul_full = acc_q * mul_weight;
	// product shifted right by 8 must fit 48 bits
	assign mul_ovf = |mul_full[CNT_W+15:CNT_W+8];

	always_ff @(posedge clk) begin
		if (acc_clear)
			acc_q <= '0;
		else if (acc_add)
			acc_q <= acc_ovf ? CNT_MAX : sum;
		if (mul_go)
			prod_q <= mul_ovf ? CNT_MAX : mul_full[CNT_W+7:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.clear_sat) begin
			sat_q <= 1'b0;
		end else if (cmd.set_sat || (acc_add && acc_ovf) || (mul_go && mul_ovf)) begin
			sat_q <= 1'b1;
		end
	end

	assign acc  = acc_q;
	assign prod = prod_q;
	assign sat  = sat_q;

endmodule

>>> rtl/npc_ctrl.sv
// sequencer for loads, reads and the two build sweeps
module npc_ctrl
	import npc_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 512,
	localparam int NW = $clog2(MAX_NODES + 1),
	localparam int EW = $clog2(MAX_EDGES),
	localparam int RW = $clog2(MAX_NODES),
	localparam int OW = $clog2(MAX_EDGES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [6:0]        node_count,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CNT_W-1:0]  out_count,
	input  logic              sat,
	output logic              off_we,
	output logic [NW-1:0]     off_waddr,
	output logic [OW-1:0]     off_wdata,
	output logic [NW-1:0]     off_raddr,
	input  logic [OW-1:0]     off_rdata,
	output logic              edge_we,
	output logic [EW-1:0]     edge_waddr,
	output logic [5:0]        edge_wpred,
	output logic [15:0]       edge_wweight,
	output logic [EW-1:0]     edge_raddr,
	input  logic [5:0]        edge_rpred,
	input  logic [15:0]       edge_rweight,
	output logic              cnt_we_a,
	output logic              cnt_we_b,
	output logic [RW+EW-1:0]  cnt_waddr,
	output logic [CNT_W-1:0]  cnt_wdata,
	output logic [RW+EW-1:0]  cnt_raddr,
	output logic              cnt_rsel,
	input  logic [CNT_W-1:0]  cnt_rdata,
	output logic              acc_clear,
	output logic              acc_add,
	input  logic [CNT_W-1:0]  acc,
	output logic              mul_go,
	output logic [15:0]       mul_weight,
	input  logic [CNT_W-1:0]  prod,
	output npc_cmd_t          cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RDW   = 5'd1;  // read count latency
	localparam logic [4:0] S_OUT   = 5'd3;
	localparam logic [4:0] S_CLR   = 5'd4;  // zero a bank
	localparam logic [4:0] S_TOT0  = 5'd5;  // fetch edge total
	localparam logic [4:0] S_TOT1  = 5'd6;
	localparam logic [4:0] S_F0    = 5'd7;  // first: read edge
	localparam logic [4:0] S_F1    = 5'd8;
	localparam logic [4:0] S_J0    = 5'd9;  // next: lo of node j
	localparam logic [4:0] S_J1    = 5'd10;
	localparam logic [4:0] S_J2    = 5'd11;
	localparam logic [4:0] S_E0    = 5'd12; // edge e pred/weight
	localparam logic [4:0] S_E1    = 5'd13;
	localparam logic [4:0] S_P0    = 5'd14; // offsets of predecessor
	localparam logic [4:0] S_P1    = 5'd15;
	localparam logic [4:0] S_P2    = 5'd16;
	localparam logic [4:0] S_Q0    = 5'd17; // walk incoming edges q
	localparam logic [4:0] S_Q1    = 5'd18;
	localparam logic [4:0] S_Q2    = 5'd19;
	localparam logic [4:0] S_MUL   = 5'd20;
	localparam logic [4:0] S_WR    = 5'd21;

	localparam int CD = MAX_NODES * MAX_EDGES;
	localparam int CW = $clog2(CD + 1);

	logic [4:0] state_q;
	logic [2:0] op_q;
	logic bank_q, active_q;
	logic [CNT_W-1:0] out_q;
	logic [CW-1:0] clr_q;
	logic [NW-1:0] n_q, i_q, j_q;
	logic [OW-1:0] s_q, hi_q, phi_q, e_q, q_q;
	logic [5:0] epred_q;
	logic [15:0] ewt_q;
	logic [NW-1:0] n_eff;
	logic [OW-1:0] off_cl;

	assign n_eff = (int'(node_count) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count);
	assign off_cl = (off_rdata > s_q) ? s_q : off_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_count = out_q;
	assign mul_weight = ewt_q;

	always_comb begin
		off_we = 1'b0; off_waddr = item.slot[NW-1:0]; off_wdata = item.offset_value[OW-1:0];
		off_raddr = n_q;
		edge_we = 1'b0; edge_waddr = item.slot[EW-1:0];
		edge_wpred = item.pred_node; edge_wweight = item.edge_weight;
		edge_raddr = e_q[EW-1:0];
		cnt_we_a = 1'b0; cnt_we_b = 1'b0; cnt_waddr = '0; cnt_wdata = '0;
		cnt_raddr = {i_q[RW-1:0], q_q[EW-1:0]};
		cnt_rsel = active_q;
		acc_clear = 1'b0; acc_add = 1'b0; mul_go = 1'b0;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cnt_raddr = {item.start_node[RW-1:0], item.slot[EW-1:0]};
				if (in_valid) begin
					off_we = (item.op == OP_LOAD_OFFSET) && (int'(item.slot) <= MAX_NODES);
					edge_we = (item.op == OP_LOAD_EDGE) && (int'(item.slot) < MAX_EDGES);
					cmd.clear_sat = (item.op == OP_BUILD_FIRST);
				end
			end
			S_CLR: begin
				cnt_waddr = clr_q[RW+EW-1:0];
				cnt_we_a = !bank_q; cnt_we_b = bank_q;
			end
			S_TOT0: off_raddr = n_q;
			S_F1: begin
				cnt_waddr = {edge_rpred[RW-1:0], e_q[EW-1:0]};
				cnt_wdata = CNT_W'(edge_rweight) << 8;
				if (e_q < s_q && NW'(edge_rpred) < n_q) begin
					cnt_we_a = !bank_q; cnt_we_b = bank_q;
				end
			end
			S_J0: off_raddr = j_q;
			S_J1: off_raddr = j_q + 1'b1;
			S_E0: acc_clear = 1'b1;
			S_P0: off_raddr = NW'(epred_q);
			S_P1: off_raddr = NW'(epred_q) + 1'b1;
			// hold the edge address so the predecessor of q is still there for the add
			S_Q0, S_Q1: edge_raddr = q_q[EW-1:0];
			S_Q2: acc_add = (NW'(edge_rpred) != j_q);
			S_MUL: mul_go = 1'b1;
			S_WR: begin
				cnt_waddr = {i_q[RW-1:0], e_q[EW-1:0]};
				cnt_wdata = prod;
				cnt_we_a = !bank_q; cnt_we_b = bank_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= 1'b0;
			op_q <= OP_LOAD_OFFSET;
			bank_q <= 1'b0;
			clr_q <= '0;
			out_q <= '0;
			n_q <= '0; i_q <= '0; j_q <= '0;
			s_q <= '0; hi_q <= '0; phi_q <= '0; e_q <= '0; q_q <= '0;
			epred_q <= '0; ewt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= item.op;
					out_q <= '0;
					n_q <= n_eff;
					clr_q <= '0;
					s_q <= OW'(MAX_EDGES);
					if (item.op == OP_READ) begin
						state_q <= (int'(item.start_node) < MAX_NODES &&
							int'(item.slot) < MAX_EDGES) ? S_RDW : S_OUT;
					end else if (item.op == OP_BUILD_FIRST) begin
						bank_q <= active_q; state_q <= S_CLR;
					end else if (item.op == OP_BUILD_NEXT) begin
						bank_q <= !active_q; state_q <= S_CLR;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_RDW: begin out_q <= cnt_rdata; state_q <= S_OUT; end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CD - 1)) state_q <= S_TOT0;
				end
				S_TOT0: state_q <= S_TOT1;
				S_TOT1: begin
					s_q <= off_cl; e_q <= '0; i_q <= '0; j_q <= '0;
					if (op_q == OP_BUILD_FIRST) state_q <= S_F0;
					else if (n_q == '0) begin
						// no rows to walk, the cleared bank still becomes active
						active_q <= bank_q; state_q <= S_OUT;
					end else state_q <= S_J0;
				end
				S_F0: state_q <= (e_q < s_q) ? S_F1 : S_OUT;
				S_F1: begin e_q <= e_q + 1'b1; state_q <= S_F0; end
				S_J0: state_q <= S_J1;
				S_J1: begin e_q <= off_cl; state_q <= S_J2; end
				S_J2: begin hi_q <= off_cl; state_q <= S_E0; end
				S_E0: begin
					if (e_q < hi_q) state_q <= S_E1;
					else if (j_q + 1'b1 < n_q) begin j_q <= j_q + 1'b1; state_q <= S_J0; end
					else if (i_q + 1'b1 < n_q) begin
						i_q <= i_q + 1'b1; j_q <= '0; state_q <= S_J0;
					end else begin
						active_q <= bank_q; state_q <= S_OUT;
					end
				end
				S_E1: begin
					epred_q <= edge_rpred; ewt_q <= edge_rweight;
					// diagonal entries and far predecessors give zero
					if (i_q == j_q || NW'(edge_rpred) >= n_q) state_q <= S_MUL;
					else state_q <= S_P0;
				end
				S_P0: state_q <= S_P1;
				S_P1: begin q_q <= off_cl; state_q <= S_P2; end
				S_P2: begin phi_q <= off_cl; state_q <= S_Q0; end
				S_Q0: state_q <= (q_q < phi_q) ? S_Q1 : S_MUL;
				S_Q1: state_q <= S_Q2;
				S_Q2: begin q_q <= q_q + 1'b1; state_q <= S_Q0; end
				S_MUL: state_q <= S_WR;
				S_WR: begin e_q <= e_q + 1'b1; state_q <= S_E0; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused;
	assign unused = ^{sat, acc};

	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output both open");
	a_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (active_q == $past(active_q)) || $past(state_q != S_IDLE))
		else $error("bank swapped while idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_q))
		else $error("result dropped");

endmodule

>>> rtl/nonbacktracking_path_count_step.sv
// Non-backtracking weighted path counter. Load offset, load edge and read items end in
// the output state, which holds the result until it is taken; an in-range read first
// waits for the count bank read. Build first clears all MAX_NODES*MAX_EDGES entries of
// the active bank, then walks the edges. Build next clears the other bank the same way,
// then per row and edge reads the predecessor's incoming edges and forms each entry;
// each table has one memory read port. One result per item; saturated is sticky.
module nonbacktracking_path_count_step
	import npc_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[2:0], slot[11:3], offset_value[21:12], pred_node[27:22],
	// edge_weight[43:28], start_node[49:44]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// count_value[47:0]
	output logic [47:0] m_tdata,
	// saturated
	output logic        m_tuser
);

	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int RW = $clog2(MAX_NODES);
	localparam int OW = $clog2(MAX_EDGES + 1);

	item_t item;
	npc_cmd_t cmd;
	logic [6:0] node_count_q;
	logic off_we, edge_we, cnt_we_a, cnt_we_b, cnt_rsel, acc_clear, acc_add, mul_go, sat;
	logic [NW-1:0] off_waddr, off_raddr;
	logic [OW-1:0] off_wdata, off_rdata;
	logic [EW-1:0] edge_waddr, edge_raddr;
	logic [5:0] edge_wpred, edge_rpred;
	logic [15:0] edge_wweight, edge_rweight, mul_weight;
	logic [RW+EW-1:0] cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0] cnt_wdata, cnt_rdata, acc, prod;

	assign item = {s_tdata[2:0], s_tdata[11:3], s_tdata[21:12], s_tdata[27:22],
		s_tdata[43:28], s_tdata[49:44]};
	assign cfg_ready = 1'b1;
	assign m_tuser = sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= 7'd1;
		else if (cfg_valid)
			node_count_q <= cfg_data;
	end

	npc_ctrl #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
		.clk, .arst_n, .node_count(node_count_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .item,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_count(m_tdata), .sat,
		.off_we, .off_waddr, .off_wdata, .off_raddr, .off_rdata,
		.edge_we, .edge_waddr, .edge_wpred, .edge_wweight, .edge_raddr,
		.edge_rpred, .edge_rweight,
		.cnt_we_a, .cnt_we_b, .cnt_waddr, .cnt_wdata, .cnt_raddr, .cnt_rsel, .cnt_rdata,
		.acc_clear, .acc_add, .acc, .mul_go, .mul_weight, .prod, .cmd);

	npc_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk, .arst_n,
		.off_we, .off_waddr, .off_wdata, .off_raddr, .off_rdata,
		.edge_we, .edge_waddr, .edge_wpred, .edge_wweight, .edge_raddr,
		.edge_rpred, .edge_rweight,
		.cnt_we_a, .cnt_we_b, .cnt_waddr, .cnt_wdata, .cnt_raddr, .cnt_rsel, .cnt_rdata,
		.acc_clear, .acc_add, .acc, .mul_go, .mul_weight, .prod, .cmd, .sat);

endmodule
